FILE: rtl/two_bit_handshake_byte_sender_defines.svh
// assertion macros for the handshake byte sender core
// no dependencies; included by tbhs_core, which carries concurrent checks
`ifndef TWO_BIT_HANDSHAKE_BYTE_SENDER_DEFINES_SVH
`define TWO_BIT_HANDSHAKE_BYTE_SENDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TBHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbhs check failed");

// next-cycle implication, disabled during reset
`define TBHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbhs check failed");

`endif

FILE: rtl/tbhs_pkg.sv
// shared types, register codes and reset values for the handshake byte sender
// no dependencies
`timescale 1ns / 1ps

package tbhs_pkg;

    localparam int LEN_W      = 16;
    localparam int TO_W       = 21;
    localparam int CFG_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 3;
    localparam int TIMER_BITS = 21;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_FIRST_WAIT    = 2'd3;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd7;

    localparam logic [LEN_W-1:0] RST_TRANSFER_LENGTH    = 16'd1;
    localparam logic [TO_W-1:0]  RST_WAIT_TIMEOUT       = 21'd500000;
    localparam logic [TO_W-1:0]  RST_FIRST_WAIT_TIMEOUT = 21'd2000000;

    typedef struct packed {
        logic [LEN_W-1:0] transfer_length;
        logic [TO_W-1:0]  wait_timeout;
        logic [TO_W-1:0]  first_wait_timeout;
        logic             long_first_wait;
    } t_cfg;

    typedef struct packed {
        logic             read_line;
        logic             sense_line;
        logic             byte_taken;
        logic [LEN_W-1:0] bytes_sent;
        logic             done_res;
        logic             timed_out;
    } t_res;

endpackage

FILE: rtl/two_bit_handshake_byte_sender.sv
// Two-wire handshake byte sender. Each request is either a byte offer or a
// one-microsecond tick carrying the sampled host write line; every request
// yields exactly one result with the read and sense line levels, whether the
// offered byte was taken, the count of bytes sent, and the done and sticky
// timeout flags. Requests are taken one per clock unless the input is stalled:
// a request is held in the input register, the combinational state update then
// writes the result register, so a result is offered from the result register
// after its request leaves the input register. A stall on the result side holds
// the request in the input register, which in turn stalls the input side.
// Configuration writes must be issued while no request is in flight.
// depends on tbhs_pkg, tbhs_cfg_regs, tbhs_core
`timescale 1ns / 1ps

module two_bit_handshake_byte_sender #(
    parameter int TIMER_BITS = tbhs_pkg::TIMER_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbhs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbhs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [tbhs_pkg::BYTE_W-1:0]    i_payload_byte,
    input  logic                           i_write_line,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_read_line,
    output logic                           o_sense_line,
    output logic                           o_byte_taken,
    output logic [tbhs_pkg::LEN_W-1:0]     o_bytes_sent,
    output logic                           o_done_res,
    output logic                           o_timed_out
);

    tbhs_pkg::t_cfg              cfg;
    tbhs_pkg::t_res              res;

    logic                        r_in_vld;
    logic                        r_opcode;
    logic [tbhs_pkg::BYTE_W-1:0] r_payload;
    logic                        r_write;
    logic                        r_out_vld;
    logic                        in_acc;
    logic                        move;

    // the request moves on when the result register is free or being emptied
    assign move       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !move;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= in_acc || (r_in_vld && !move);
            r_out_vld <= move || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode  <= i_opcode;
            r_payload <= i_payload_byte;
            r_write   <= i_write_line;
        end
    end

    tbhs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tbhs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_proc         (move),
        .i_opcode       (r_opcode),
        .i_payload_byte (r_payload),
        .i_write_line   (r_write),
        .o_res          (res)
    );

    assign o_out_valid  = r_out_vld;
    assign o_read_line  = res.read_line;
    assign o_sense_line = res.sense_line;
    assign o_byte_taken = res.byte_taken;
    assign o_bytes_sent = res.bytes_sent;
    assign o_done_res   = res.done_res;
    assign o_timed_out  = res.timed_out;

endmodule

FILE: rtl/tbhs_cfg_regs.sv
// configuration register file for the handshake byte sender
// depends on tbhs_pkg
`timescale 1ns / 1ps

module tbhs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbhs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbhs_pkg::CFG_W-1:0]     i_cfg_data,
    output tbhs_pkg::t_cfg                 o_cfg
);

    tbhs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transfer_length    <= tbhs_pkg::RST_TRANSFER_LENGTH;
            r_cfg.wait_timeout       <= tbhs_pkg::RST_WAIT_TIMEOUT;
            r_cfg.first_wait_timeout <= tbhs_pkg::RST_FIRST_WAIT_TIMEOUT;
            r_cfg.long_first_wait    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbhs_pkg::CFG_TRANSFER_LENGTH: begin
                    r_cfg.transfer_length <= i_cfg_data[tbhs_pkg::LEN_W-1:0];
                end
                tbhs_pkg::CFG_WAIT_TIMEOUT: begin
                    r_cfg.wait_timeout <= i_cfg_data[tbhs_pkg::TO_W-1:0];
                end
                tbhs_pkg::CFG_FIRST_WAIT_TIMEOUT: begin
                    r_cfg.first_wait_timeout <= i_cfg_data[tbhs_pkg::TO_W-1:0];
                end
                tbhs_pkg::CFG_LONG_FIRST_WAIT: begin
                    r_cfg.long_first_wait <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tbhs_core.sv
// sender state update and result register: one request per cycle while i_proc is high
// depends on tbhs_pkg and two_bit_handshake_byte_sender_defines.svh
`timescale 1ns / 1ps
`include "two_bit_handshake_byte_sender_defines.svh"

module tbhs_core #(
    parameter int TIMER_BITS = tbhs_pkg::TIMER_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tbhs_pkg::t_cfg              i_cfg,
    input  logic                        i_proc,
    input  logic                        i_opcode,
    input  logic [tbhs_pkg::BYTE_W-1:0] i_payload_byte,
    input  logic                        i_write_line,
    output tbhs_pkg::t_res              o_res
);

    localparam int CW = (TIMER_BITS + 1 > tbhs_pkg::TO_W) ? TIMER_BITS + 1 : tbhs_pkg::TO_W;

    logic [tbhs_pkg::BYTE_W-1:0]  r_shift, n_shift;
    logic [tbhs_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                         r_holding, n_holding;
    logic [TIMER_BITS-1:0]        r_wait, n_wait;
    logic                         r_first_over, n_first_over;
    logic [tbhs_pkg::LEN_W-1:0]   r_sent, n_sent;
    logic                         r_final, n_final;
    logic                         r_finished, n_finished;
    logic                         r_error, n_error;
    logic [1:0]                   r_lines, n_lines;
    logic                         n_taken;
    tbhs_pkg::t_res               r_res;

    logic                         stopped;
    logic                         enter_final;
    logic                         in_wait;
    logic                         exp_lvl;
    logic                         hit;
    logic [TIMER_BITS-1:0]        wt_base;
    logic [TIMER_BITS:0]          wt_next;
    logic [tbhs_pkg::TO_W-1:0]    limit;
    logic                         overrun;
    logic [tbhs_pkg::BYTE_W-1:0]  inv;
    logic [tbhs_pkg::LEN_W-1:0]   sent_inc;

    always_comb begin
        stopped     = r_finished | r_error;
        enter_final = !r_holding && !r_final && (r_sent >= i_cfg.transfer_length);
        in_wait     = r_holding || r_final || enter_final;
        exp_lvl     = r_holding ? r_phase[0] : 1'b0;
        hit         = (i_write_line == exp_lvl);
        wt_base     = enter_final ? '0 : r_wait;
        wt_next     = {1'b0, wt_base} + {{TIMER_BITS{1'b0}}, 1'b1};
        // the long timeout only covers the first wait until it succeeds
        limit       = (i_cfg.long_first_wait && !r_first_over) ?
                      i_cfg.first_wait_timeout : i_cfg.wait_timeout;
        overrun     = CW'(wt_next) > CW'(limit);
        inv         = ~i_payload_byte;
        sent_inc    = r_sent + 1'b1;

        n_shift      = r_shift;
        n_phase      = r_phase;
        n_holding    = r_holding;
        n_wait       = r_wait;
        n_first_over = r_first_over;
        n_sent       = r_sent;
        n_final      = r_final;
        n_finished   = r_finished;
        n_error      = r_error;
        n_lines      = r_lines;
        n_taken      = 1'b0;

        if (i_opcode == tbhs_pkg::OP_BYTE) begin
            if (!stopped && !r_holding && !r_final &&
                (r_sent < i_cfg.transfer_length)) begin
                n_shift   = {inv[5:0], inv[7:6]};
                n_phase   = '0;
                n_holding = 1'b1;
                n_wait    = '0;
                n_taken   = 1'b1;
            end
        end else if (!stopped && in_wait) begin
            if (enter_final) begin
                n_final = 1'b1;
            end
            if (hit) begin
                n_wait = '0;
                if (i_cfg.long_first_wait) begin
                    n_first_over = 1'b1;
                end
                if (r_holding) begin
                    if (!r_phase[0]) begin
                        n_lines = {1'b0, r_shift[7]};
                    end else begin
                        n_lines = {1'b1, r_shift[6]};
                        n_shift = {r_shift[5:0], 2'b00};
                    end
                    if (r_phase == tbhs_pkg::LAST_PHASE) begin
                        n_phase   = '0;
                        n_holding = 1'b0;
                        n_sent    = sent_inc;
                        if (sent_inc >= i_cfg.transfer_length) begin
                            n_final = 1'b1;
                        end
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end else begin
                    n_final    = 1'b0;
                    n_finished = 1'b1;
                end
            end else begin
                if (overrun) begin
                    n_error = 1'b1;
                end
                n_wait = wt_next[TIMER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= '0;
            r_phase      <= '0;
            r_holding    <= 1'b0;
            r_wait       <= '0;
            r_first_over <= 1'b0;
            r_sent       <= '0;
            r_final      <= 1'b0;
            r_finished   <= 1'b0;
            r_error      <= 1'b0;
            r_lines      <= '0;
        end else if (i_proc) begin
            r_shift      <= n_shift;
            r_phase      <= n_phase;
            r_holding    <= n_holding;
            r_wait       <= n_wait;
            r_first_over <= n_first_over;
            r_sent       <= n_sent;
            r_final      <= n_final;
            r_finished   <= n_finished;
            r_error      <= n_error;
            r_lines      <= n_lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_proc) begin
            r_res.read_line  <= n_lines[0];
            r_res.sense_line <= n_lines[1];
            r_res.byte_taken <= n_taken;
            r_res.bytes_sent <= n_sent;
            r_res.done_res   <= n_finished;
            r_res.timed_out  <= n_error;
        end
    end

    assign o_res = r_res;

    `TBHS_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_error, r_error)
    `TBHS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_finished, !r_holding && !r_final)
    `TBHS_ASSERT_NEXT(a_take_holds, i_clk, i_rst_n, i_proc && n_taken, r_holding && r_phase == '0)
    `TBHS_ASSERT_NOW(a_hold_not_final, i_clk, i_rst_n, r_holding, !r_final)

endmodule
